// File: hw/rtl/bright_pass_filter_top_macros.svh
// Assertion macros for the bright-pass filter.
// Used by files that assert; expects i_clk and i_rst_n in scope.
`ifndef BRIGHT_PASS_FILTER_TOP_MACROS_SVH
`define BRIGHT_PASS_FILTER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bright pass check failed");

// antecedent implies consequent in the next cycle
`define BPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bright pass check failed");

`endif

// File: hw/rtl/bpf_pkg.sv
// Shared constants for the bright-pass filter.
// No dependencies.
package bpf_pkg;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;
    localparam logic [32:0] BIAS_EPS = 33'd66;
    localparam logic [31:0] FIVE_Q  = 32'd327680;
    localparam logic [32:0] TEN_Q   = 33'd655360;

    localparam logic [31:0] MG_RESET  = 32'd11796;
    localparam logic [31:0] THR_RESET = 32'd65536;

    localparam logic REG_MG  = 1'b0;
    localparam logic REG_THR = 1'b1;

    localparam int LANE_LAT = 87;
    localparam int TOP_LAT  = LANE_LAT + 3;

endpackage

// File: hw/rtl/bright_pass_filter_top.sv
// Bright-pass filter top: config registers, luminance, three lanes, output merge.
// Depends on bpf_pkg, bpf_lane and bright_pass_filter_top_macros.svh.
//
// Usage:
//   Pixels enter on i_red_in/i_green_in/i_blue_in/i_last_in; a transfer happens
//   at each clock edge with i_start high and o_busy low. o_busy stays low, so a
//   new pixel may enter every cycle: throughput is one pixel per clock.
//   Each pixel gives one result on o_red_out/o_green_out/o_blue_out/o_last_out,
//   shown for one cycle with o_done high.
//   The latency is set by three pipelined restoring dividers per lane
//   (32 + 32 + 16 stages) plus multiply, luminance and merge registers.
//   Results leave in input order; the receiver cannot stall and none is needed.
//   Configuration: i_cfg_we with i_cfg_idx (0 middle grey, 1 threshold) and
//   i_cfg_data writes a register at once; write only while no pixel is in flight.
//   Synchronous reset (i_rst_n low) empties the pipeline and restores the
//   registers to middle grey 0.18 and threshold 1.0.
`include "bright_pass_filter_top_macros.svh"
module bright_pass_filter_top
    import bpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_red_in,
    input  logic [31:0] i_green_in,
    input  logic [31:0] i_blue_in,
    input  logic        i_last_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic        o_last_out
);

    logic [31:0] r_mg;
    logic [31:0] r_thr;
    logic [63:0] r_tsq;
    logic        w_acc;
    logic [TOP_LAT-1:0] r_vld;
    logic [TOP_LAT-1:0] r_last;
    logic [47:0] r_pr;
    logic [47:0] r_pg;
    logic [47:0] r_pb;
    logic [31:0] r_ch_a [3];
    logic [31:0] r_ch_b [3];
    logic [47:0] w_sum;
    logic [32:0] r_den;
    logic [15:0] w_pix [3];
    logic [15:0] r_out [3];
    logic        w_dark;
    logic        w_zero_out;

    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mg  <= MG_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MG:  r_mg  <= i_cfg_data;
                REG_THR: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsq <= 64'(r_thr) * 64'(r_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOP_LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[TOP_LAT-2:0], i_last_in};
    end

    // luminance
    always_ff @(posedge i_clk) begin
        r_pr      <= 48'(i_red_in) * 48'(W_RED);
        r_pg      <= 48'(i_green_in) * 48'(W_GREEN);
        r_pb      <= 48'(i_blue_in) * 48'(W_BLUE);
        r_ch_a[0] <= i_red_in;
        r_ch_a[1] <= i_green_in;
        r_ch_a[2] <= i_blue_in;
        r_den     <= {1'b0, w_sum[47:16]} + BIAS_EPS;
        r_ch_b    <= r_ch_a;
    end

    assign w_sum = r_pr + r_pg + r_pb;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bpf_lane u_lane (
            .i_clk  (i_clk),
            .i_chan (r_ch_b[g]),
            .i_den  (r_den),
            .i_mg   (r_mg),
            .i_tsq  (r_tsq),
            .o_pix  (w_pix[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_out <= w_pix;
    end

    assign o_done      = r_vld[TOP_LAT-1];
    assign o_last_out  = r_last[TOP_LAT-1];
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];

    // a zero threshold saturates the boost even for a dark pixel
    assign w_dark     = (i_red_in == '0) && (i_green_in == '0) && (i_blue_in == '0);
    assign w_zero_out = ({o_red_out, o_green_out, o_blue_out} == '0);

    `BPF_ASSERT_IMP(a_done_src, o_done, $past(w_acc, TOP_LAT))
    `BPF_ASSERT_IMP(a_last_align, o_done, o_last_out == $past(i_last_in, TOP_LAT))
    `BPF_ASSERT_IMP(a_dark_zero, o_done && r_tsq != '0 && $past(w_dark, TOP_LAT), w_zero_out)
    `BPF_ASSERT_NXT(a_busy_low, 1'b1, !o_busy)

endmodule

// File: hw/rtl/bpf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by bpf_lane. Remainder input must be below the divisor.
module bpf_div #(
    parameter int DW = 33,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_dvs,
    input  logic          i_sat,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_dvs [QW];
    logic          r_sat [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_low;
        logic [QW-1:0] w_q;
        logic [DW-1:0] w_dvs;
        logic          w_sat;
        logic [DW:0]   w_trial;

        if (g == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_low = i_low;
            assign w_q   = '0;
            assign w_dvs = i_dvs;
            assign w_sat = i_sat;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_low = r_low[g-1];
            assign w_q   = r_q[g-1];
            assign w_dvs = r_dvs[g-1];
            assign w_sat = r_sat[g-1];
        end

        assign w_trial = {w_rem, w_low[QW-1]};

        always_ff @(posedge i_clk) begin
            if (w_trial >= {1'b0, w_dvs}) begin
                r_rem[g] <= DW'(w_trial - {1'b0, w_dvs});
                r_q[g]   <= {w_q[QW-2:0], 1'b1};
            end else begin
                r_rem[g] <= w_trial[DW-1:0];
                r_q[g]   <= {w_q[QW-2:0], 1'b0};
            end
            r_low[g] <= {w_low[QW-2:0], 1'b0};
            r_dvs[g] <= w_dvs;
            r_sat[g] <= w_sat;
        end
    end

    assign o_quo = r_sat[QW-1] ? '1 : r_q[QW-1];

endmodule

// File: hw/rtl/bpf_lane.sv
// One color lane: scale, boost, threshold and compress one channel.
// Depends on bpf_pkg and bpf_div.
module bpf_lane
    import bpf_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_chan,
    input  logic [32:0] i_den,
    input  logic [31:0] i_mg,
    input  logic [63:0] i_tsq,
    output logic [15:0] o_pix
);

    logic [63:0] r_prod;
    logic [32:0] r_den0;
    logic [32:0] r_rem1;
    logic [31:0] r_low1;
    logic [32:0] r_dvs1;
    logic        r_sat1;
    logic [31:0] w_q1;
    logic [31:0] r_s;
    logic [63:0] r_sq;
    logic [31:0] r_s3;
    logic [63:0] r_rem2;
    logic [31:0] r_low2;
    logic        r_sat2;
    logic [31:0] r_s4;
    logic [31:0] r_sdly [32];
    logic [31:0] w_p;
    logic [32:0] w_t;
    logic [31:0] w_tsat;
    logic [31:0] r_u;
    logic [32:0] r_rem3;
    logic [32:0] r_dvs3;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_chan) * 64'(i_mg);
        r_den0 <= i_den;
        r_sat1 <= {1'b0, r_prod[63:32]} >= r_den0;
        r_rem1 <= {1'b0, r_prod[63:32]};
        r_low1 <= r_prod[31:0];
        r_dvs1 <= r_den0;
    end

    bpf_div #(.DW(33), .QW(32)) u_div_scale (
        .i_clk (i_clk),
        .i_rem (r_rem1),
        .i_low (r_low1),
        .i_dvs (r_dvs1),
        .i_sat (r_sat1),
        .o_quo (w_q1)
    );

    always_ff @(posedge i_clk) begin
        r_s    <= w_q1;
        r_sq   <= 64'(r_s) * 64'(r_s);
        r_s3   <= r_s;
        r_sat2 <= {16'b0, r_sq[63:16]} >= i_tsq;
        r_rem2 <= {16'b0, r_sq[63:16]};
        r_low2 <= {r_sq[15:0], 16'b0};
        r_s4   <= r_s3;
        r_sdly[0] <= r_s4;
        for (int k = 1; k < 32; k++) begin
            r_sdly[k] <= r_sdly[k-1];
        end
    end

    bpf_div #(.DW(64), .QW(32)) u_div_boost (
        .i_clk (i_clk),
        .i_rem (r_rem2),
        .i_low (r_low2),
        .i_dvs (i_tsq),
        .i_sat (r_sat2),
        .o_quo (w_p)
    );

    assign w_t    = {1'b0, r_sdly[31]} + {1'b0, w_p};
    assign w_tsat = w_t[32] ? '1 : w_t[31:0];

    always_ff @(posedge i_clk) begin
        r_u    <= (w_tsat > FIVE_Q) ? (w_tsat - FIVE_Q) : '0;
        r_rem3 <= {1'b0, r_u};
        r_dvs3 <= {1'b0, r_u} + TEN_Q;
    end

    bpf_div #(.DW(33), .QW(16)) u_div_comp (
        .i_clk (i_clk),
        .i_rem (r_rem3),
        .i_low ('0),
        .i_dvs (r_dvs3),
        .i_sat (1'b0),
        .o_quo (o_pix)
    );

endmodule

// File: dv/tb_top.sv
// Testbench for bright_pass_filter_top: drives HDR pixels, predicts bright-pass results.
// Depends on bpf_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 100ps
module tb_top;
    import bpf_pkg::*;

    localparam logic [31:0] FULL_Q   = 32'hFFFF_FFFF;
    localparam int          LIMIT    = 400000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
    } t_bright_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [31:0] i_red_in = '0;
    logic [31:0] i_green_in = '0;
    logic [31:0] i_blue_in = '0;
    logic        i_last_in = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_MG;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;
    logic        o_last_out;

    logic [31:0] grey_q;
    logic [31:0] thresh_q;
    t_bright_px  pending_px[$];
    int          mismatches = 0;
    int          pixels_sent = 0;
    int          results_seen = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;

    always #6 i_clk = ~i_clk;

    bright_pass_filter_top i_dut (.*);

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** bright_pass_filter_top: FAILED **");
            $finish;
        end
    end

    // floor(a * 65536 / b) saturated to 32 bits
    function automatic logic [31:0] q16_ratio(logic [63:0] a, logic [63:0] b);
        logic [127:0] q;
        q = ({64'd0, a} << 16) / {64'd0, b};
        return (q > FULL_Q) ? FULL_Q : q[31:0];
    endfunction

    function automatic logic [15:0] bright_of(logic [31:0] c, logic [32:0] den);
        logic [63:0] s64;
        logic [31:0] s;
        logic [31:0] p;
        logic [32:0] t;
        logic [32:0] u;
        logic [63:0] frac;
        s64 = ({32'd0, c} * {32'd0, grey_q}) / {31'd0, den};
        s = (s64 > FULL_Q) ? FULL_Q : s64[31:0];
        if (thresh_q == 0)
            p = FULL_Q;
        else
            p = q16_ratio({32'd0, s} * {32'd0, s}, {32'd0, thresh_q} * {32'd0, thresh_q});
        t = {1'b0, s} + {1'b0, p};
        if (t > FULL_Q) t = {1'b0, FULL_Q};
        u = (t > FIVE_Q) ? t - FIVE_Q : '0;
        frac = ({31'd0, u} << 16) / ({31'd0, u} + {31'd0, TEN_Q});
        return frac[15:0];
    endfunction

    function automatic t_bright_px predict_px(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                              logic l);
        logic [63:0] lum;
        logic [32:0] den;
        t_bright_px px;
        lum = ({48'd0, W_RED} * r + {48'd0, W_GREEN} * g + {48'd0, W_BLUE} * b) >> 16;
        den = lum[32:0] + BIAS_EPS;
        px.red = bright_of(r, den);
        px.green = bright_of(g, den);
        px.blue = bright_of(b, den);
        px.last = l;
        return px;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_bright_px want;
        if (i_rst_n && o_done) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected result", {15'd0, o_red_out, o_last_out}, '0);
            end else begin
                want = pending_px.pop_front();
                if (o_red_out !== want.red)
                    report_mismatch("red", 32'(o_red_out), 32'(want.red));
                if (o_green_out !== want.green)
                    report_mismatch("green", 32'(o_green_out), 32'(want.green));
                if (o_blue_out !== want.blue)
                    report_mismatch("blue", 32'(o_blue_out), 32'(want.blue));
                if (o_last_out !== want.last)
                    report_mismatch("last", 32'(o_last_out), 32'(want.last));
            end
            results_seen++;
        end
    end

    // one pixel transfer; random bursts and gaps when paced
    task automatic send_px(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic l, bit paced);
        int gap;
        if (paced) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                if (gap != 0) begin
                    i_start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        i_start <= 1'b1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        i_last_in <= l;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_px.push_back(predict_px(r, g, b, l));
        pixels_sent++;
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (TOP_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MG) grey_q = val; else thresh_q = val;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FULL_Q;
            2: return $urandom_range(0, 32'h0004_0000);
            3: return $urandom_range(0, 32'h0100_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed;
        send_px('0, '0, '0, 1'b0, 0);
        send_px(FULL_Q, FULL_Q, FULL_Q, 1'b1, 0);
        send_px(FULL_Q, '0, '0, 1'b0, 0);
        send_px('0, FULL_Q, '0, 1'b1, 0);
        send_px('0, '0, FULL_Q, 1'b0, 0);
        send_px(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 0);
        send_px(32'd1, '0, '0, 1'b1, 0);
        send_px(32'h000A_0000, 32'd1, 32'h0000_8000, 1'b0, 0);
        send_px(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1, 0);
        drain();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_px(rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(0, 1)), 1);
        drain();
    endtask

    task automatic test_config_sweep;
        write_reg(REG_MG, '0);
        write_reg(REG_THR, 32'd1);
        test_random(40);
        write_reg(REG_MG, FULL_Q);
        write_reg(REG_THR, FULL_Q);
        test_random(40);
        write_reg(REG_THR, '0);
        test_directed();
        test_random(30);
        write_reg(REG_MG, 32'd65536);
        write_reg(REG_THR, 32'd32768);
        test_random(40);
        write_reg(REG_MG, $urandom());
        write_reg(REG_THR, $urandom_range(1, 32'h0010_0000));
        test_random(60);
        write_reg(REG_MG, MG_RESET);
        write_reg(REG_THR, THR_RESET);
        test_random(100);
    endtask

    initial begin
        grey_q = MG_RESET;
        thresh_q = THR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(80);
        test_config_sweep();
        $display("sent %0d pixels, checked %0d results over six register settings",
                 pixels_sent, results_seen);
        if (mismatches == 0 && pending_px.size() == 0)
            $display("** bright_pass_filter_top: PASSED **");
        else
            $display("** bright_pass_filter_top: FAILED **");
        $finish;
    end
endmodule
